// ----- src/bgrm_pkg.sv -----
package bgrm_pkg;

  // Model size; the index field is 16 bits, so at most 65536 entries are addressable.
  localparam int unsigned PIXELS     = 65536;
  localparam int unsigned MEM_DEPTH  = (PIXELS > 65536) ? 65536 : PIXELS;
  localparam int unsigned ADDR_W     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned PIX_W      = 8;

  // Raw func codes on the input port.
  localparam logic [2:0] FUNC_SEED        = 3'd0;
  localparam logic [2:0] FUNC_GROW_STEP   = 3'd1;
  localparam logic [2:0] FUNC_GROW_MINMAX = 3'd2;
  localparam logic [2:0] FUNC_COUNT       = 3'd3;
  localparam logic [2:0] FUNC_ADJUST      = 3'd4;
  localparam logic [2:0] FUNC_SHIFT       = 3'd5;

  typedef enum logic [2:0] {
    OP_SEED,
    OP_GROW_STEP,
    OP_GROW_MINMAX,
    OP_COUNT,
    OP_ADJUST,
    OP_SHIFT,
    OP_NONE
  } op_e;

  typedef struct packed {
    logic [PIX_W-1:0] lo;
    logic [PIX_W-1:0] hi;
    logic [PIX_W-1:0] bc;
    logic [PIX_W-1:0] ac;
  } entry_t;

  // Classified item handed from front to back.
  typedef struct packed {
    op_e              op;
    logic             in_range;
    logic [IDX_W-1:0] index;
    logic [PIX_W-1:0] value;
    logic             enable;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0] index;
    entry_t           entry;
  } result_t;

  function automatic logic [PIX_W-1:0] sat_add(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    logic [PIX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[PIX_W] ? {PIX_W{1'b1}} : s[PIX_W-1:0];
  endfunction

  function automatic logic [PIX_W-1:0] sat_sub(input logic [PIX_W-1:0] a,
                                               input logic [PIX_W-1:0] b);
    return (a > b) ? (a - b) : '0;
  endfunction

  function automatic logic [PIX_W-1:0] step(input logic [PIX_W-1:0] v,
                                            input logic up, input logic down);
    logic [PIX_W-1:0] r;
    r = v;
    if (up) begin
      r = sat_add(v, PIX_W'(1));
    end else if (down) begin
      r = sat_sub(v, PIX_W'(1));
    end
    return r;
  endfunction

  // One update of a pixel entry.
  function automatic entry_t apply_op(input item_t it, input entry_t e,
                                      input logic [PIX_W-1:0] thr);
    entry_t           r;
    logic [PIX_W-1:0] add;
    logic [PIX_W-1:0] sub;
    r   = e;
    add = sat_sub(it.value, e.hi);
    sub = sat_sub(e.lo, it.value);
    case (it.op)
      OP_SEED: begin
        r.lo = it.value;
        r.hi = it.value;
        r.bc = '0;
        r.ac = '0;
      end
      OP_GROW_STEP: begin
        if (it.value < e.lo) r.lo = sat_sub(e.lo, PIX_W'(1));
        if (it.value > e.hi) r.hi = sat_add(e.hi, PIX_W'(1));
      end
      OP_GROW_MINMAX: begin
        if (it.value < e.lo) r.lo = it.value;
        if (it.value > e.hi) r.hi = it.value;
      end
      OP_COUNT: begin
        if (it.value < e.lo) r.bc = sat_add(e.bc, PIX_W'(1));
        if (it.value > e.hi) r.ac = sat_add(e.ac, PIX_W'(1));
      end
      OP_ADJUST: begin
        if (it.enable) begin
          r.lo = step(e.lo, e.bc < thr, e.bc > thr);
          r.hi = step(e.hi, e.ac > thr, e.ac < thr);
        end
        r.bc = '0;
        r.ac = '0;
      end
      OP_SHIFT: begin
        if (it.enable) begin
          r.lo = sat_sub(sat_add(e.lo, add), sub);
          r.hi = sat_sub(sat_add(e.hi, add), sub);
        end
      end
      default: begin
        r = e;
      end
    endcase
    return r;
  endfunction

endpackage

// ----- src/background_range_model_top.sv -----
// Per-pixel min/max background model. Every beat pushed names a pixel, its
// 8-bit value, an operation (seed, grow step, grow min/max, count, adjust,
// shift) and an update enable; each produces exactly one result beat showing
// that pixel's low/high bounds and below/above counts after the operation,
// in push order. Throughput is one beat per clock while the result queue
// is not full: every item is a read-modify-write of its own 32-bit entry in
// a single-write, single-read model memory, and a same-pixel item that
// follows directly is served from a bypass register, so no pattern of
// pixels costs a bubble. A pushed item passes a front queue slot, the
// execute stage (memory read) and the result queue write before its result
// is visible. Pixels at or above PIXELS echo
// their index with zero fields and leave the model untouched. Entries hold
// garbage until first written (normally by a seed); there is no clearing
// pass. count_threshold is written through the cfg channel, always ready,
// and must only change while the block is drained.
module background_range_model_top import bgrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // config channel
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [PIX_W-1:0] cfg_data_i,
  // item queue side
  input  logic             push,
  output logic             full,
  input  logic [2:0]       func_i,
  input  logic [IDX_W-1:0] pixel_index_i,
  input  logic [PIX_W-1:0] pixel_value_i,
  input  logic             update_enable_i,
  // result queue side
  output logic             empty,
  input  logic             pop,
  output logic [IDX_W-1:0] pixel_echo_o,
  output logic [PIX_W-1:0] low_out_o,
  output logic [PIX_W-1:0] high_out_o,
  output logic [PIX_W-1:0] below_out_o,
  output logic [PIX_W-1:0] above_out_o
);

  logic [PIX_W-1:0] threshold_q, threshold_d;
  logic             item_valid;
  item_t            item;
  logic             item_pop;
  result_t          result;

  // Threshold register; the channel never back-pressures.
  assign cfg_ready_o = 1'b1;

  always_comb begin
    threshold_d = threshold_q;
    if (cfg_valid_i && cfg_ready_o) begin
      threshold_d = cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
    end else begin
      threshold_q <= threshold_d;
    end
  end

  // Front: decode and range check, two-deep queue toward the back end.
  bgrm_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .func_i         (func_i),
    .pixel_index_i  (pixel_index_i),
    .pixel_value_i  (pixel_value_i),
    .update_enable_i(update_enable_i),
    .item_valid_o   (item_valid),
    .item_o         (item),
    .item_pop_i     (item_pop)
  );

  // Back: model memory read-modify-write with bypass, result queue.
  bgrm_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .threshold_i (threshold_q),
    .item_valid_i(item_valid),
    .item_i      (item),
    .item_pop_o  (item_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result)
  );

  assign pixel_echo_o = result.index;
  assign low_out_o    = result.entry.lo;
  assign high_out_o   = result.entry.hi;
  assign below_out_o  = result.entry.bc;
  assign above_out_o  = result.entry.ac;

endmodule

// ----- src/bgrm_front.sv -----
module bgrm_front import bgrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic [2:0]       func_i,
  input  logic [IDX_W-1:0] pixel_index_i,
  input  logic [PIX_W-1:0] pixel_value_i,
  input  logic             update_enable_i,
  output logic             item_valid_o,
  output item_t            item_o,
  input  logic             item_pop_i
);

  item_t      slot_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  item_t      cls;
  logic       do_push, do_pop;

  // Classify: decode func and range-check the index.
  always_comb begin
    cls.index    = pixel_index_i;
    cls.value    = pixel_value_i;
    cls.enable   = update_enable_i;
    cls.in_range = ({16'b0, pixel_index_i} < 32'(PIXELS));
    case (func_i)
      FUNC_SEED:        cls.op = OP_SEED;
      FUNC_GROW_STEP:   cls.op = OP_GROW_STEP;
      FUNC_GROW_MINMAX: cls.op = OP_GROW_MINMAX;
      FUNC_COUNT:       cls.op = OP_COUNT;
      FUNC_ADJUST:      cls.op = OP_ADJUST;
      FUNC_SHIFT:       cls.op = OP_SHIFT;
      default:          cls.op = OP_NONE;
    endcase
  end

  assign full         = (cnt_q == 2'd2);
  assign item_valid_o = (cnt_q != 2'd0);
  assign item_o       = slot_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_pop_i && item_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

endmodule

// ----- src/bgrm_back.sv -----
module bgrm_back import bgrm_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [PIX_W-1:0] threshold_i,
  input  logic             item_valid_i,
  input  item_t            item_i,
  output logic             item_pop_o,
  output logic             empty,
  input  logic             pop,
  output result_t          result_o
);

  entry_t      mem [MEM_DEPTH];

  // Execute stage: item whose entry read is in flight.
  logic        ex_valid_q, ex_valid_d;
  item_t       ex_item_q;
  entry_t      rd_q;
  logic        fwd_q;
  entry_t      fwd_data_q;

  // Result queue.
  result_t     res_q [2];
  logic        rwr_ptr_q, rwr_ptr_d;
  logic        rrd_ptr_q, rrd_ptr_d;
  logic [1:0]  rcnt_q, rcnt_d;

  logic        res_full;
  logic        ex_fire;
  logic        take;
  entry_t      old_entry;
  entry_t      new_entry;
  result_t     res;
  logic        do_rpop;
  logic [ADDR_W-1:0] take_addr, ex_addr;

  assign res_full   = (rcnt_q == 2'd2);
  assign ex_fire    = ex_valid_q && !res_full;
  assign take       = item_valid_i && (!ex_valid_q || ex_fire);
  assign item_pop_o = take;
  assign take_addr  = item_i.index[ADDR_W-1:0];
  assign ex_addr    = ex_item_q.index[ADDR_W-1:0];

  // Entry written this cycle bypasses the memory for a same-pixel follower.
  assign old_entry  = fwd_q ? fwd_data_q : rd_q;
  assign new_entry  = apply_op(ex_item_q, old_entry, threshold_i);

  always_comb begin
    res.index = ex_item_q.index;
    res.entry = ex_item_q.in_range ? new_entry : '0;
  end

  always_comb begin
    ex_valid_d = ex_valid_q;
    if (take) begin
      ex_valid_d = 1'b1;
    end else if (ex_fire) begin
      ex_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ex_valid_q <= 1'b0;
    end else begin
      ex_valid_q <= ex_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      ex_item_q  <= item_i;
      rd_q       <= mem[take_addr];
      fwd_q      <= ex_fire && ex_item_q.in_range && (ex_addr == take_addr);
      fwd_data_q <= new_entry;
    end
    if (ex_fire && ex_item_q.in_range) begin
      mem[ex_addr] <= new_entry;
    end
  end

  // Result queue.
  assign empty    = (rcnt_q == 2'd0);
  assign result_o = res_q[rrd_ptr_q];
  assign do_rpop  = pop && !empty;

  always_comb begin
    rwr_ptr_d = rwr_ptr_q ^ ex_fire;
    rrd_ptr_d = rrd_ptr_q ^ do_rpop;
    rcnt_d    = rcnt_q + {1'b0, ex_fire} - {1'b0, do_rpop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rwr_ptr_q <= 1'b0;
      rrd_ptr_q <= 1'b0;
      rcnt_q    <= 2'd0;
    end else begin
      rwr_ptr_q <= rwr_ptr_d;
      rrd_ptr_q <= rrd_ptr_d;
      rcnt_q    <= rcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ex_fire) begin
      res_q[rwr_ptr_q] <= res;
    end
  end

endmodule
